>>> rtl/core/svsd_pkg.sv
// ============================================================================
// svsd_pkg
// Shared types, op codes and controller states for the sparse vector store.
// ============================================================================
package svsd_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int INDEX_BITS_DEF    = 16;
    localparam int VALUE_BITS_DEF    = 32;

    // Port field widths
    localparam int OP_W     = 3;
    localparam int IDX_W    = 16;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    localparam logic [OP_W-1:0] OP_SET   = 3'd0;
    localparam logic [OP_W-1:0] OP_GET   = 3'd1;
    localparam logic [OP_W-1:0] OP_REM   = 3'd2;
    localparam logic [OP_W-1:0] OP_ADD   = 3'd3;
    localparam logic [OP_W-1:0] OP_DOT   = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SAT  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC,
        S_MUL,
        S_ACC,
        S_OUT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // capture input beat, start scan
        logic scan;      // advance scan pointer
        logic exec;      // perform table update / result formation
        logic mul;       // register product
        logic acc;       // accumulate product
        logic emit;      // present result beat
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic scan_done;
        logic is_dot;
    } t_stat;

endpackage

>>> rtl/core/svsd_if.sv
// ============================================================================
// svsd_in_if / svsd_out_if
// Valid/ready channels for input items and result items.
// ============================================================================
interface svsd_in_if;
    import svsd_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         op;
    logic [IDX_W-1:0]        item_index;
    logic signed [VAL_W-1:0] item_value;
    logic                    last_element;
    modport source (output valid, op, item_index, item_value, last_element, input ready);
    modport sink   (input valid, op, item_index, item_value, last_element, output ready);
endinterface

interface svsd_out_if;
    import svsd_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] result_value;
    logic                    found;
    logic [STATUS_W-1:0]     status;
    logic                    sum_ready;
    logic [COUNT_W-1:0]      entry_count;
    logic [IDX_W-1:0]        highest_index;
    modport source (output valid, result_value, found, status, sum_ready, entry_count,
                    highest_index, input ready);
    modport sink   (input valid, result_value, found, status, sum_ready, entry_count,
                    highest_index, output ready);
endinterface

>>> rtl/core/svsd_ctrl.sv
// ============================================================================
// svsd_ctrl
// Sequencer: accept beat, scan table, optional multiply/accumulate, execute,
// hold result until taken.
// ============================================================================
module svsd_ctrl
    import svsd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                // Hold off input beats while reset is asserted
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = i_stat.is_dot ? S_MUL : S_EXEC;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                o_cmd.emit  = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Input is taken only when no item is in flight
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid) else $error("ready while result pending");
    a_load_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == S_SCAN) else $error("load did not start scan");
    a_acc_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.acc |=> o_cmd.exec) else $error("accumulate not followed by exec");

endmodule

>>> rtl/core/svsd_dp.sv
// ============================================================================
// svsd_dp
// Datapath: entry table in memory, serial search, update logic, Q32.32
// saturating accumulator.
// ============================================================================
module svsd_dp
    import svsd_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int INDEX_BITS    = INDEX_BITS_DEF,
    parameter int VALUE_BITS    = VALUE_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_stat                   o_stat,
    input  logic [OP_W-1:0]         i_op,
    input  logic [IDX_W-1:0]        i_item_index,
    input  logic signed [VAL_W-1:0] i_item_value,
    input  logic                    i_last_element,
    output logic signed [VAL_W-1:0] o_result_value,
    output logic                    o_found,
    output logic [STATUS_W-1:0]     o_status,
    output logic                    o_sum_ready,
    output logic [COUNT_W-1:0]      o_entry_count,
    output logic [IDX_W-1:0]        o_highest_index
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int PW = 2 * VALUE_BITS;
    localparam logic signed [VALUE_BITS:0] VMAX = (VALUE_BITS+1)'((64'sd1 <<< (VALUE_BITS-1)) - 1);
    localparam logic signed [VALUE_BITS:0] VMIN = -VMAX - 1;
    localparam logic signed [63:0] A_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] A_MIN = 64'sh8000_0000_0000_0000;

    // Entry storage: valid bits in flops, index/value in memory
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [INDEX_BITS-1:0]    m_index [TABLE_ENTRIES];
    logic [VALUE_BITS-1:0]    m_value [TABLE_ENTRIES];

    // Captured beat
    logic [OP_W-1:0]               r_op;
    logic [INDEX_BITS-1:0]         r_idx;
    logic signed [VALUE_BITS-1:0]  r_val;
    logic                          r_last;

    // Scan state
    logic [CW-1:0]                 r_ptr;      // address being read (+1 = issued)
    logic                          r_rd_vld;   // read data below belongs to r_rd_addr
    logic [AW-1:0]                 r_rd_addr;
    logic [INDEX_BITS-1:0]         r_rd_index;
    logic [VALUE_BITS-1:0]         r_rd_value;
    logic                          r_hit;
    logic [AW-1:0]                 r_hit_pos;
    logic signed [VALUE_BITS-1:0]  r_hit_val;
    logic                          r_free;
    logic [AW-1:0]                 r_free_pos;

    logic signed [PW-1:0]          r_prod;
    logic signed [63:0]            r_acc;
    logic [CW-1:0]                 r_count;
    logic [INDEX_BITS-1:0]         r_top;

    // Result register
    logic signed [VAL_W-1:0]       r_res;
    logic                          r_found;
    logic [STATUS_W-1:0]           r_status;
    logic                          r_sready;

    logic                          scan_last;
    logic signed [VALUE_BITS-1:0]  cur_val;
    logic signed [VALUE_BITS+1:0]  sum_wide;
    logic signed [VALUE_BITS-1:0]  sum_sat;
    logic signed [64:0]            acc_sum;
    logic signed [63:0]            acc_next;
    logic signed [47:0]            q_floor;
    logic signed [VALUE_BITS-1:0]  q_sat;
    logic                          q_ovf;

    assign scan_last     = r_ptr == CW'(TABLE_ENTRIES);
    assign o_stat.scan_done = scan_last && !r_rd_vld;
    assign o_stat.is_dot = r_op == OP_DOT;

    assign cur_val  = r_hit ? r_hit_val : '0;
    assign sum_wide = (VALUE_BITS+2)'(cur_val) + (VALUE_BITS+2)'(r_val);
    always_comb begin
        if (sum_wide > (VALUE_BITS+2)'(VMAX)) sum_sat = VMAX[VALUE_BITS-1:0];
        else if (sum_wide < (VALUE_BITS+2)'(VMIN)) sum_sat = VMIN[VALUE_BITS-1:0];
        else sum_sat = sum_wide[VALUE_BITS-1:0];
    end

    // Saturating accumulate
    assign acc_sum = 65'(r_acc) + 65'(r_prod);
    always_comb begin
        if (acc_sum > 65'(A_MAX)) acc_next = A_MAX;
        else if (acc_sum < 65'(A_MIN)) acc_next = A_MIN;
        else acc_next = acc_sum[63:0];
    end

    // Floor to Q16.16 is an arithmetic shift, then narrow
    assign q_floor = r_acc[63:16];
    always_comb begin
        q_ovf = 1'b0;
        q_sat = q_floor[VALUE_BITS-1:0];
        if (q_floor > 48'(VMAX)) begin
            q_sat = VMAX[VALUE_BITS-1:0];
            q_ovf = 1'b1;
        end else if (q_floor < 48'(VMIN)) begin
            q_sat = VMIN[VALUE_BITS-1:0];
            q_ovf = 1'b1;
        end
    end

    // Memory read port, one entry a cycle
    always_ff @(posedge i_clk) begin
        r_rd_index <= m_index[r_ptr[AW-1:0]];
        r_rd_value <= m_value[r_ptr[AW-1:0]];
        r_rd_addr  <= r_ptr[AW-1:0];
    end

    // Scan, capture and arithmetic registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_op;
            r_idx  <= i_item_index[INDEX_BITS-1:0];
            r_val  <= VALUE_BITS'(i_item_value);
            r_last <= i_last_element;
        end
        if (i_cmd.mul) begin
            r_prod <= PW'(cur_val) * PW'(r_val);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr    <= '0;
            r_rd_vld <= 1'b0;
            r_hit    <= 1'b0;
            r_free   <= 1'b0;
        end else if (i_cmd.load) begin
            r_ptr    <= '0;
            r_rd_vld <= 1'b0;
            r_hit    <= 1'b0;
            r_free   <= 1'b0;
        end else if (i_cmd.scan) begin
            r_rd_vld <= !scan_last;
            if (!scan_last) r_ptr <= r_ptr + 1'b1;
            if (r_rd_vld) begin
                if (r_valid[r_rd_addr] && r_rd_index == r_idx && !r_hit) begin
                    r_hit     <= 1'b1;
                    r_hit_pos <= r_rd_addr;
                    r_hit_val <= r_rd_value;
                end
                if (!r_valid[r_rd_addr] && !r_free) begin
                    r_free     <= 1'b1;
                    r_free_pos <= r_rd_addr;
                end
            end
        end
    end

    // Execute: table update, counters and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_acc   <= '0;
            r_count <= '0;
            r_top   <= '0;
        end else begin
            if (i_cmd.acc) r_acc <= acc_next;
            if (i_cmd.exec) begin
                r_res    <= '0;
                r_found  <= r_hit && r_op <= OP_DOT;
                r_status <= ST_OK;
                r_sready <= 1'b0;
                case (r_op)
                    OP_SET, OP_ADD: begin
                        if (r_op == OP_ADD && sum_sat == '0) begin
                            if (r_hit) begin
                                r_valid[r_hit_pos] <= 1'b0;
                                r_count <= r_count - 1'b1;
                            end
                        end else begin
                            if (r_idx > r_top) r_top <= r_idx;
                            if (r_hit) begin
                                r_res <= VAL_W'(r_op == OP_ADD ? sum_sat : r_val);
                            end else if (r_free) begin
                                r_valid[r_free_pos] <= 1'b1;
                                r_count <= r_count + 1'b1;
                                r_res <= VAL_W'(r_op == OP_ADD ? sum_sat : r_val);
                            end else begin
                                r_status <= ST_FULL;
                            end
                        end
                    end
                    OP_GET: r_res <= VAL_W'(cur_val);
                    OP_REM: begin
                        r_res <= VAL_W'(cur_val);
                        if (r_hit) begin
                            r_valid[r_hit_pos] <= 1'b0;
                            r_count <= r_count - 1'b1;
                        end
                    end
                    OP_DOT: begin
                        if (r_last) begin
                            r_res    <= VAL_W'(q_sat);
                            r_status <= q_ovf ? ST_SAT : ST_OK;
                            r_sready <= 1'b1;
                            r_acc    <= '0;
                        end
                    end
                    OP_CLEAR: begin
                        r_valid <= '0;
                        r_count <= '0;
                        r_top   <= '0;
                        r_acc   <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Memory write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && (r_op == OP_SET || (r_op == OP_ADD && sum_sat != '0))) begin
            if (r_hit) begin
                m_value[r_hit_pos] <= r_op == OP_ADD ? sum_sat : r_val;
            end else if (r_free) begin
                m_index[r_free_pos] <= r_idx;
                m_value[r_free_pos] <= r_op == OP_ADD ? sum_sat : r_val;
            end
        end
    end

    assign o_result_value  = r_res;
    assign o_found         = r_found;
    assign o_status        = r_status;
    assign o_sum_ready     = r_sready;
    assign o_entry_count   = COUNT_W'(r_count);
    assign o_highest_index = IDX_W'(r_top);

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_ENTRIES)) else $error("entry count overflow");
    a_hit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && r_hit) |-> r_valid[r_hit_pos]) else $error("hit on invalid slot");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && r_op == OP_CLEAR) |=> (r_count == '0 && r_valid == '0))
        else $error("clear incomplete");

endmodule

>>> rtl/core/sparse_vector_store_dot.sv
// ============================================================================
// sparse_vector_store_dot
// Sparse vector table with set/get/remove/add-into/clear and dot stepping.
// ============================================================================
// One item at a time: each item is searched serially through the entry
// memory, one entry per cycle, and a dot step adds a multiply and an
// accumulate step before its result forms; the result then holds until taken
// and the next item is accepted the cycle after. Values are signed Q16.16,
// the dot accumulator is saturating Q32.32.
module sparse_vector_store_dot
    import svsd_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int INDEX_BITS    = INDEX_BITS_DEF,
    parameter int VALUE_BITS    = VALUE_BITS_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    svsd_in_if.sink    i_item,
    svsd_out_if.source o_result
);

    t_cmd  cmd;
    t_stat stat;

    svsd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    svsd_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .INDEX_BITS    (INDEX_BITS),
        .VALUE_BITS    (VALUE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_op            (i_item.op),
        .i_item_index    (i_item.item_index),
        .i_item_value    (i_item.item_value),
        .i_last_element  (i_item.last_element),
        .o_result_value  (o_result.result_value),
        .o_found         (o_result.found),
        .o_status        (o_result.status),
        .o_sum_ready     (o_result.sum_ready),
        .o_entry_count   (o_result.entry_count),
        .o_highest_index (o_result.highest_index)
    );

endmodule
